// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is held
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked property, also checked through reset
`define ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: sv/vtlo_pkg.sv
// ----------------------------------------------------------------------------
// vtlo_pkg
// Shared types and constants of the vertex tint, light and offset block.
// ----------------------------------------------------------------------------
package vtlo_pkg;

    localparam int S_TDATA_W   = 480;
    localparam int M_TDATA_W   = 224;
    localparam int PIPE_STAGES = 4;

    // mode field
    localparam int MODE_TINT_BIT = 0;
    localparam int MODE_DIFF_BIT = 1;
    localparam logic [1:0] MODE_NONE = 2'b00;

    localparam logic [7:0]  FP_EXP_MAX   = 8'hFF;
    localparam logic [31:0] FP_QNAN_DFLT = 32'hFFC0_0000;

    typedef struct packed {
        logic        sign;
        logic [7:0]  expo;
        logic [22:0] mant;
    } fp32_t;

endpackage

// File: sv/vtlo_pos_lane.sv
// ----------------------------------------------------------------------------
// vtlo_pos_lane
// One position axis: double offset rounded to single, then a three-stage
// single-precision adder (align, add, normalize and round).
// ----------------------------------------------------------------------------
module vtlo_pos_lane
    import vtlo_pkg::*;
(
    input  logic        aclk,
    input  logic        ce,
    input  logic [31:0] pos_in,
    input  logic [63:0] off_in,
    output logic [31:0] sum_out
);

    // ---------------- stage 1: double to single ----------------
    logic               ds;
    logic [10:0]        de;
    logic [51:0]        dm;
    logic signed [12:0] ue;
    logic signed [12:0] sh_full;
    logic [5:0]         sh;
    logic [116:0]       dext;
    logic [23:0]        dkeep;
    logic               dguard, dsticky, drnd;
    logic [7:0]         dexpf;
    logic [30:0]        dmag;
    logic [31:0]        d2f;

    always_comb begin
        ds      = off_in[63];
        de      = off_in[62:52];
        dm      = off_in[51:0];
        ue      = $signed({2'b00, de}) - 13'sd1023;
        sh_full = (ue >= -13'sd126) ? 13'sd29 : (-13'sd97 - ue);
        sh      = (sh_full > 13'sd63) ? 6'd63 : sh_full[5:0];
        dext    = {1'b1, dm, 64'b0} >> sh;
        dkeep   = dext[87:64];
        dguard  = dext[63];
        dsticky = |dext[62:0];
        drnd    = dguard & (dsticky | dkeep[0]);
        dexpf   = (ue >= -13'sd126) ? 8'(ue + 13'sd127) : 8'd0;
        dmag    = {dexpf, dkeep[22:0]} + 31'(drnd);
        if (de == 11'h7FF) begin
            d2f = (dm != 52'd0) ? {ds, FP_EXP_MAX, 1'b1, dm[50:29]} : {ds, FP_EXP_MAX, 23'd0};
        end else if (de == 11'd0) begin
            d2f = {ds, 31'd0};
        end else if (ue > 13'sd127) begin
            d2f = {ds, FP_EXP_MAX, 23'd0};
        end else begin
            d2f = {ds, dmag};
        end
    end

    logic [31:0] s1_off_reg, s1_pos_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_off_reg <= d2f;
            s1_pos_reg <= pos_in;
        end
    end

    // ---------------- stage 2: specials, swap, align ----------------
    fp32_t       fa, fb, fbig, fsml;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        spec_next;
    logic [31:0] spec_val_next;
    logic [7:0]  eb_eff, es_eff, ediff;
    logic [4:0]  dc;
    logic [26:0] sig_big, sig_sml, al_next;
    logic [53:0] aext;

    always_comb begin
        fa    = fp32_t'(s1_off_reg);
        fb    = fp32_t'(s1_pos_reg);
        a_nan = (fa.expo == FP_EXP_MAX) && (fa.mant != 23'd0);
        b_nan = (fb.expo == FP_EXP_MAX) && (fb.mant != 23'd0);
        a_inf = (fa.expo == FP_EXP_MAX) && (fa.mant == 23'd0);
        b_inf = (fb.expo == FP_EXP_MAX) && (fb.mant == 23'd0);
        spec_next     = 1'b1;
        spec_val_next = s1_off_reg;
        // first operand's NaN wins, quieted
        if (a_nan) begin
            spec_val_next = {fa.sign, FP_EXP_MAX, 1'b1, fa.mant[21:0]};
        end else if (b_nan) begin
            spec_val_next = {fb.sign, FP_EXP_MAX, 1'b1, fb.mant[21:0]};
        end else if (a_inf && b_inf && (fa.sign != fb.sign)) begin
            spec_val_next = FP_QNAN_DFLT;
        end else if (a_inf) begin
            spec_val_next = s1_off_reg;
        end else if (b_inf) begin
            spec_val_next = s1_pos_reg;
        end else begin
            spec_next = 1'b0;
        end
        if (s1_off_reg[30:0] >= s1_pos_reg[30:0]) begin
            fbig = fa;
            fsml = fb;
        end else begin
            fbig = fb;
            fsml = fa;
        end
        eb_eff  = (fbig.expo == 8'd0) ? 8'd1 : fbig.expo;
        es_eff  = (fsml.expo == 8'd0) ? 8'd1 : fsml.expo;
        ediff   = eb_eff - es_eff;
        dc      = (ediff >= 8'd27) ? 5'd27 : ediff[4:0];
        sig_big = {fbig.expo != 8'd0, fbig.mant, 3'b000};
        sig_sml = {fsml.expo != 8'd0, fsml.mant, 3'b000};
        aext    = {sig_sml, 27'd0} >> dc;
        al_next = aext[53:27] | {26'd0, |aext[26:0]};
    end

    logic [26:0] s2_big_reg, s2_al_reg;
    logic [7:0]  s2_eb_reg;
    logic        s2_sign_reg, s2_sub_reg, s2_spec_reg;
    logic [31:0] s2_spec_val_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_big_reg      <= sig_big;
            s2_al_reg       <= al_next;
            s2_eb_reg       <= eb_eff;
            s2_sign_reg     <= fbig.sign;
            s2_sub_reg      <= fa.sign ^ fb.sign;
            s2_spec_reg     <= spec_next;
            s2_spec_val_reg <= spec_val_next;
        end
    end

    // ---------------- stage 3: add and count leading zeros ----------------
    logic [27:0] sum_next;
    logic [4:0]  lz_next;

    always_comb begin
        sum_next = s2_sub_reg ? ({1'b0, s2_big_reg} - {1'b0, s2_al_reg})
                              : ({1'b0, s2_big_reg} + {1'b0, s2_al_reg});
        lz_next  = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (sum_next[i]) begin
                lz_next = 5'(26 - i);
            end
        end
    end

    logic [27:0] s3_sum_reg;
    logic [4:0]  s3_lz_reg;
    logic [7:0]  s3_eb_reg;
    logic        s3_sign_reg, s3_sub_reg, s3_spec_reg;
    logic [31:0] s3_spec_val_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_sum_reg      <= sum_next;
            s3_lz_reg       <= lz_next;
            s3_eb_reg       <= s2_eb_reg;
            s3_sign_reg     <= s2_sign_reg;
            s3_sub_reg      <= s2_sub_reg;
            s3_spec_reg     <= s2_spec_reg;
            s3_spec_val_reg <= s2_spec_val_reg;
        end
    end

    // ---------------- stage 4: normalize, round, pack ----------------
    logic [26:0] norm;
    logic [8:0]  nexp;
    logic [7:0]  shl;
    logic        rg, rs, rr;
    logic [30:0] rmag;
    logic        rsign;
    logic [31:0] res_next;

    always_comb begin
        if (s3_sum_reg[27]) begin
            norm = s3_sum_reg[27:1] | {26'd0, s3_sum_reg[0]};
            nexp = {1'b0, s3_eb_reg} + 9'd1;
            shl  = 8'd0;
        end else begin
            // stop at the subnormal boundary
            shl  = ({3'b000, s3_lz_reg} < s3_eb_reg) ? {3'b000, s3_lz_reg}
                                                      : (s3_eb_reg - 8'd1);
            norm = s3_sum_reg[26:0] << shl;
            nexp = norm[26] ? ({1'b0, s3_eb_reg} - {1'b0, shl}) : 9'd0;
        end
        rg    = norm[2];
        rs    = |norm[1:0];
        rr    = rg & (rs | norm[3]);
        rmag  = {nexp[7:0], norm[25:3]} + 31'(rr);
        rsign = (s3_sum_reg == 28'd0 && s3_sub_reg) ? 1'b0 : s3_sign_reg;
        if (s3_spec_reg) begin
            res_next = s3_spec_val_reg;
        end else if (nexp >= 9'd255) begin
            res_next = {rsign, FP_EXP_MAX, 23'd0};
        end else begin
            res_next = {rsign, rmag};
        end
    end

    logic [31:0] s4_res_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_res_reg <= res_next;
        end
    end

    assign sum_out = s4_res_reg;

endmodule

// File: sv/vtlo_color_unit.sv
// ----------------------------------------------------------------------------
// vtlo_color_unit
// Per-channel color scaling: factor multiply, factor rounding, byte
// multiply, then round, truncate and keep the low byte.
// ----------------------------------------------------------------------------
module vtlo_color_unit
    import vtlo_pkg::*;
(
    input  logic        aclk,
    input  logic        ce,
    input  logic [31:0] color_in,
    input  logic [1:0]  mode_in,
    input  logic [23:0] tint_in,
    input  logic [31:0] diff_in,
    output logic [31:0] color_out
);

    localparam int INV_DEN = 255;

    // correctly rounded k / 255.0f; the quotient is never a tie
    function automatic logic [31:0] inv255_bits(input int k);
        longint     num;
        longint     q;
        longint     r;
        int         n;
        logic       found;
        logic [31:0] res;
        n     = 0;
        found = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (!found && ((longint'(k) << i) >= INV_DEN)) begin
                n     = i;
                found = 1'b1;
            end
        end
        num = longint'(k) << (23 + n);
        q   = num / INV_DEN;
        r   = num - q * INV_DEN;
        if (2 * r > INV_DEN) begin
            q = q + 1;
        end
        res = (k == 0) ? 32'd0 : {1'b0, 8'(127 - n), q[22:0]};
        return res;
    endfunction

    logic [31:0] inv_lut [256];

    for (genvar k = 0; k < 256; k++) begin : g_lut
        assign inv_lut[k] = inv255_bits(k);
    end

    // ---------------- stage 1: factor multiply ----------------
    fp32_t fd;
    logic  use_t, use_d;

    assign fd    = fp32_t'(diff_in);
    assign use_t = mode_in[MODE_TINT_BIT];
    assign use_d = mode_in[MODE_DIFF_BIT];

    logic [47:0]        s1_prod_reg [3];
    logic signed [9:0]  s1_exp_reg  [3];
    logic [2:0]         s1_kill_reg;
    logic               s1_sign_reg;
    logic [31:0]        s1_color_reg;
    logic [1:0]         s1_mode_reg;

    for (genvar c = 0; c < 3; c++) begin : g_s1
        logic [7:0]  tb;
        logic [31:0] lut;
        logic [23:0] lsig, dsig;
        logic [7:0]  lexp, dexp;

        always_comb begin
            tb   = tint_in[23-8*c -: 8];
            lut  = inv_lut[tb];
            // a mode that skips a factor multiplies by exactly 1.0
            lsig = use_t ? {1'b1, lut[22:0]} : 24'h80_0000;
            lexp = use_t ? lut[30:23] : 8'd127;
            dsig = use_d ? {1'b1, fd.mant} : 24'h80_0000;
            dexp = use_d ? fd.expo : 8'd127;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                s1_prod_reg[c] <= lsig * dsig;
                s1_exp_reg[c]  <= $signed({2'b00, lexp}) + $signed({2'b00, dexp}) - 10'sd254;
                // zero, subnormal, infinite or NaN factor ends in a zero byte
                s1_kill_reg[c] <= (use_t && tb == 8'd0) ||
                                  (use_d && (fd.expo == 8'd0 || fd.expo == FP_EXP_MAX));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_sign_reg  <= use_d & fd.sign;
            s1_color_reg <= color_in;
            s1_mode_reg  <= mode_in;
        end
    end

    // ---------------- stage 2: round the factor ----------------
    logic [23:0]        s2_sig_reg  [3];
    logic signed [9:0]  s2_exp_reg  [3];
    logic [2:0]         s2_kill_reg;
    logic               s2_sign_reg;
    logic [31:0]        s2_color_reg;
    logic [1:0]         s2_mode_reg;

    for (genvar c = 0; c < 3; c++) begin : g_s2
        logic [23:0]       sig;
        logic              g, st;
        logic [24:0]       rnd;
        logic signed [9:0] e;

        always_comb begin
            if (s1_prod_reg[c][47]) begin
                sig = s1_prod_reg[c][47:24];
                g   = s1_prod_reg[c][23];
                st  = |s1_prod_reg[c][22:0];
                e   = s1_exp_reg[c] + 10'sd1;
            end else begin
                sig = s1_prod_reg[c][46:23];
                g   = s1_prod_reg[c][22];
                st  = |s1_prod_reg[c][21:0];
                e   = s1_exp_reg[c];
            end
            rnd = {1'b0, sig} + 25'(g & (st | sig[0]));
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                s2_sig_reg[c]  <= rnd[24] ? 24'h80_0000 : rnd[23:0];
                s2_exp_reg[c]  <= rnd[24] ? (e + 10'sd1) : e;
                s2_kill_reg[c] <= s1_kill_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_sign_reg  <= s1_sign_reg;
            s2_color_reg <= s1_color_reg;
            s2_mode_reg  <= s1_mode_reg;
        end
    end

    // ---------------- stage 3: byte times factor ----------------
    logic [31:0]        s3_p_reg    [3];
    logic signed [9:0]  s3_exp_reg  [3];
    logic [2:0]         s3_kill_reg;
    logic               s3_sign_reg;
    logic [31:0]        s3_color_reg;
    logic [1:0]         s3_mode_reg;

    for (genvar c = 0; c < 3; c++) begin : g_s3
        always_ff @(posedge aclk) begin
            if (ce) begin
                s3_p_reg[c]    <= s2_color_reg[8*c +: 8] * s2_sig_reg[c];
                s3_exp_reg[c]  <= s2_exp_reg[c];
                s3_kill_reg[c] <= s2_kill_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_sign_reg  <= s2_sign_reg;
            s3_color_reg <= s2_color_reg;
            s3_mode_reg  <= s2_mode_reg;
        end
    end

    // ---------------- stage 4: round, truncate, low byte ----------------
    logic [7:0] byte_next [3];

    for (genvar c = 0; c < 3; c++) begin : g_s4
        logic [3:0]         k, kk;
        logic [40:0]        pext;
        logic [23:0]        r0, rv;
        logic [24:0]        r1;
        logic               g, st;
        logic signed [10:0] s;
        logic signed [10:0] ns;
        logic [23:0]        shv;
        logic [7:0]         mag;

        always_comb begin
            k = 4'd0;
            for (int i = 0; i < 9; i++) begin
                if (s3_p_reg[c][23+i]) begin
                    k = 4'(i);
                end
            end
            pext = {s3_p_reg[c], 9'd0} >> k;
            r0   = pext[32:9];
            g    = pext[8];
            st   = |pext[7:0];
            r1   = {1'b0, r0} + 25'(g & (st | r0[0]));
            rv   = r1[24] ? r1[24:1] : r1[23:0];
            kk   = r1[24] ? (k + 4'd1) : k;
            s    = $signed({7'd0, kk}) + {s3_exp_reg[c][9], s3_exp_reg[c]} - 11'sd23;
            ns   = -s;
            shv  = 24'd0;
            if (s >= 11'sd8) begin
                mag = 8'd0;
            end else if (s >= 11'sd0) begin
                shv = rv << s[2:0];
                mag = shv[7:0];
            end else if (s <= -11'sd24) begin
                mag = 8'd0;
            end else begin
                shv = rv >> ns[4:0];
                mag = shv[7:0];
            end
            if (s3_kill_reg[c] || s3_p_reg[c] == 32'd0) begin
                byte_next[c] = 8'd0;
            end else begin
                byte_next[c] = s3_sign_reg ? (8'd0 - mag) : mag;
            end
        end
    end

    logic [31:0] s4_color_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_color_reg <= (s3_mode_reg == MODE_NONE) ? s3_color_reg
                          : {s3_color_reg[31:24], byte_next[2], byte_next[1], byte_next[0]};
        end
    end

    assign color_out = s4_color_reg;

endmodule

// File: sv/vertex_tint_light_offset.sv
// ----------------------------------------------------------------------------
// vertex_tint_light_offset
// Per-vertex color modulate and position translate, one vertex per clock unless m_axis stalls.
//
//   channel   dir  beat contents
//   s_axis    in   position, color, texture, brightness, mode, tint,
//                  diffuse, double offsets (474 bits in 480)
//   m_axis    out  offset position, color, texture, light (224 bits)
//
// The adder's align, add and normalize stages sit behind the double-to-single
// stage. One beat enters per clock while m_axis is not stalled.
// aresetn clears the valid bits only; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; s_axis_tready drops only
// while the output holds a beat that has not been taken.
// ----------------------------------------------------------------------------
module vertex_tint_light_offset
    import vtlo_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pos_x, pos_y, pos_z, color, tex_uv, brightness, mode, tint_color,
    // diffuse_factor, off_x, off_y, off_z, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_x, out_y, out_z, out_color, out_tex_uv, out_light
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic                   ce;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;

    // advance unless the output beat is stuck
    assign ce            = !vld_reg[PIPE_STAGES-1] || m_axis_tready;
    assign s_axis_tready = ce;
    assign vld_next      = {vld_reg[PIPE_STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    logic [31:0] out_x, out_y, out_z, out_color;

    vtlo_pos_lane u_lane_x (
        .aclk    (aclk),
        .ce      (ce),
        .pos_in  (s_axis_tdata[31:0]),
        .off_in  (s_axis_tdata[345:282]),
        .sum_out (out_x)
    );

    vtlo_pos_lane u_lane_y (
        .aclk    (aclk),
        .ce      (ce),
        .pos_in  (s_axis_tdata[63:32]),
        .off_in  (s_axis_tdata[409:346]),
        .sum_out (out_y)
    );

    vtlo_pos_lane u_lane_z (
        .aclk    (aclk),
        .ce      (ce),
        .pos_in  (s_axis_tdata[95:64]),
        .off_in  (s_axis_tdata[473:410]),
        .sum_out (out_z)
    );

    vtlo_color_unit u_color (
        .aclk      (aclk),
        .ce        (ce),
        .color_in  (s_axis_tdata[127:96]),
        .mode_in   (s_axis_tdata[225:224]),
        .tint_in   (s_axis_tdata[249:226]),
        .diff_in   (s_axis_tdata[281:250]),
        .color_out (out_color)
    );

    // texture and light words ride along
    logic [95:0] pass_reg [PIPE_STAGES];

    always_ff @(posedge aclk) begin
        if (ce) begin
            pass_reg[0] <= s_axis_tdata[223:128];
            for (int i = 1; i < PIPE_STAGES; i++) begin
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_STAGES-1];
    assign m_axis_tdata  = {pass_reg[PIPE_STAGES-1], out_color, out_z, out_y, out_x};

endmodule

// File: sv/vtlo_checker.sv
// ----------------------------------------------------------------------------
// vtlo_checker
// Port-level checks of the vertex tint, light and offset block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtlo_checker
    import vtlo_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic                   flow4;
    logic [PIPE_STAGES-2:0] rdy_hist_reg;
    logic [PIPE_STAGES-1:0] rst_hist_reg;
    logic [PIPE_STAGES-1:0] acc_hist_reg;

    always_ff @(posedge aclk) begin
        rdy_hist_reg <= {rdy_hist_reg[PIPE_STAGES-3:0], m_axis_tready};
        rst_hist_reg <= {rst_hist_reg[PIPE_STAGES-2:0], aresetn};
        acc_hist_reg <= {acc_hist_reg[PIPE_STAGES-2:0], s_axis_tvalid && s_axis_tready};
    end

    // ready and out of reset over all history, beat taken at the oldest slot
    assign flow4 = m_axis_tready && (&rdy_hist_reg) && (&rst_hist_reg)
                && acc_hist_reg[PIPE_STAGES-1];

    `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
    `ASSERT_CLK(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")
    `ASSERT_CLK(a_latency, flow4 |-> m_axis_tvalid && (m_axis_tdata[223:128] == $past(s_axis_tdata[223:128], PIPE_STAGES)), "beat lost or texture and light altered")
    `ASSERT_CLK(a_color_pass, flow4 && $past(s_axis_tdata[225:224] == MODE_NONE, PIPE_STAGES) |-> m_axis_tdata[127:96] == $past(s_axis_tdata[127:96], PIPE_STAGES), "color changed with no mode set")
    `ASSERT_RST(a_reset_empty, !aresetn |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind vertex_tint_light_offset vtlo_checker u_vtlo_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_tint_light_offset: a directed table of
// vertices, then random vertices, each one scored against a typed result or a
// bit-exact single-precision predictor of color scale and position offset.
// ----------------------------------------------------------------------------
module tb;
    import vtlo_pkg::*;

    typedef struct packed {
        logic [5:0]  pad;
        logic [63:0] off_z;
        logic [63:0] off_y;
        logic [63:0] off_x;
        logic [31:0] diffuse;
        logic [23:0] tint;
        logic [1:0]  mode;
        logic [31:0] brightness;
        logic [63:0] tex_uv;
        logic [31:0] color;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } vertex_t;

    typedef struct packed {
        logic [31:0] light;
        logic [63:0] tex_uv;
        logic [31:0] color;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } shaded_t;

    typedef struct {
        vertex_t v;
        bit      typed;
        shaded_t want;
    } vec_row_t;

    localparam logic [1:0] MODE_TINT = 2'b01;
    localparam logic [1:0] MODE_DIFF = 2'b10;
    localparam logic [1:0] MODE_BOTH = 2'b11;
    localparam int N_RANDOM = 1930;
    localparam int HOLD_LEN = 90;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // pos_x, pos_y, pos_z, color, tex_uv, brightness, mode, tint_color,
    // diffuse_factor, off_x, off_y, off_z, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // out_x, out_y, out_z, out_color, out_tex_uv, out_light
    logic [M_TDATA_W-1:0] m_axis_tdata;

    shaded_t  pending_q[$];
    vec_row_t vec_rows[$];
    int       n_sent = 0;
    int       n_seen = 0;
    int       n_bad = 0;
    bit       no_idle = 1'b0;
    bit       hold_req = 1'b0;

    vertex_tint_light_offset u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // single-precision arithmetic: every op is done exactly enough in
    // double and then rounded once to single, nearest even
    // ------------------------------------------------------------------
    function automatic logic [63:0] sgl_to_dbl(logic [31:0] b);
        logic [7:0]  e;
        logic [23:0] mm;
        int          ex;
        e = b[30:23];
        mm = {1'b0, b[22:0]};
        ex = -126;
        if (e == 8'hFF) return {b[31], 11'h7FF, b[22:0], 29'b0};
        if (e == 8'h00 && mm == 0) return {b[31], 63'b0};
        if (e != 8'h00) return {b[31], 11'(int'(e) - 127 + 1023), b[22:0], 29'b0};
        while (!mm[23]) begin
            mm = mm << 1;
            ex = ex - 1;
        end
        return {b[31], 11'(ex + 1023), mm[22:0], 29'b0};
    endfunction

    function automatic logic [31:0] dbl_to_sgl(logic [63:0] d);
        logic [10:0] e;
        logic [63:0] full, kept, rest, half, mag;
        int          ex, sh;
        e = d[62:52];
        if (e == 11'h7FF) begin
            if (d[51:0] != 0) return {d[63], 8'hFF, d[51:29] | 23'h400000};
            return {d[63], 8'hFF, 23'b0};
        end
        if (e == 11'h000) return {d[63], 31'b0};
        ex = int'(e) - 1023 + 127;
        sh = (ex >= 1) ? 29 : 30 - ex;
        if (sh > 63) sh = 63;
        full = {11'b0, 1'b1, d[51:0]};
        kept = full >> sh;
        rest = full - (kept << sh);
        half = 64'd1 << (sh - 1);
        if (rest > half || (rest == half && kept[0])) kept = kept + 1;
        mag = (ex >= 1) ? ((64'(ex - 1) << 23) + kept) : kept;
        if (mag >= 64'h7F80_0000) mag = 64'h7F80_0000;
        return {d[63], mag[30:0]};
    endfunction

    function automatic real as_real(logic [31:0] b);
        return $bitstoreal(sgl_to_dbl(b));
    endfunction

    function automatic logic [31:0] to_sgl(real r);
        return dbl_to_sgl($realtobits(r));
    endfunction

    // a + b in single; a NaN in the first operand wins, quieted
    function automatic logic [31:0] add_sgl(logic [31:0] a, logic [31:0] b);
        bit a_nan, b_nan, a_inf, b_inf;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (a_nan) return a | 32'h0040_0000;
        if (b_nan) return b | 32'h0040_0000;
        if (a_inf && b_inf && (a[31] != b[31])) return FP_QNAN_DFLT;
        return to_sgl(as_real(a) + as_real(b));
    endfunction

    // float(byte) * factor, truncated, low 8 bits; NaN or huge gives zero
    function automatic logic [7:0] scale_channel(logic [7:0] c, logic [31:0] k);
        real p, lim;
        p = as_real(to_sgl(real'(c) * as_real(k)));
        lim = as_real(to_sgl(4.6e18));
        if (!(p > -lim && p < lim)) return 8'd0;
        if (p >= 2147483648.0 || p <= -2147483648.0) return 8'd0;
        return 8'($rtoi(p));
    endfunction

    function automatic shaded_t shade_vertex(vertex_t v);
        shaded_t     o;
        logic [31:0] k[3];
        logic [7:0]  ch[3];
        o.light = v.brightness;
        o.tex_uv = v.tex_uv;
        o.color = v.color;
        if (v.mode != MODE_NONE) begin
            for (int i = 0; i < 3; i++) begin
                if (v.mode[MODE_TINT_BIT]) begin
                    // red factor from the top tint byte
                    k[i] = to_sgl(real'(v.tint[23 - 8*i -: 8]) / 255.0);
                    if (v.mode[MODE_DIFF_BIT])
                        k[i] = to_sgl(as_real(k[i]) * as_real(v.diffuse));
                end else begin
                    k[i] = v.diffuse;
                end
                ch[i] = scale_channel(v.color[8*i +: 8], k[i]);
            end
            o.color = {v.color[31:24], ch[2], ch[1], ch[0]};
        end
        o.x = add_sgl(dbl_to_sgl(v.off_x), v.pos_x);
        o.y = add_sgl(dbl_to_sgl(v.off_y), v.pos_y);
        o.z = add_sgl(dbl_to_sgl(v.off_z), v.pos_z);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // random field values, biased toward sensible geometry
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_sgl();
        logic [31:0] specials[7];
        specials = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return specials[$urandom_range(0, 6)];
            2: return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
            default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [63:0] rand_dbl();
        case ($urandom_range(0, 11))
            0: return {$urandom, $urandom};
            1: return {1'($urandom), 11'h7FF, 52'($urandom_range(0, 1)) << 51};
            2: return {1'($urandom), 11'($urandom_range(1023 - 152, 1023 - 124)),
                       20'($urandom), $urandom};
            3: return {1'($urandom), 11'($urandom_range(1023 + 125, 1023 + 129)),
                       20'($urandom), $urandom};
            // near a rounding tie of the single result
            4: return {1'($urandom), 11'($urandom_range(1013, 1033)),
                       20'($urandom), 3'($urandom), 1'b1, 28'($urandom_range(0, 1))};
            default: return {1'($urandom), 11'($urandom_range(1003, 1043)),
                             20'($urandom), $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand_diffuse();
        if ($urandom_range(0, 4) == 0) return rand_sgl();
        if ($urandom_range(0, 9) == 0) return {1'b1, 8'($urandom_range(110, 127)), 23'($urandom)};
        return {1'b0, 8'($urandom_range(110, 127)), 23'($urandom)};
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        v.pad = '0;
        v.pos_x = rand_sgl();
        v.pos_y = rand_sgl();
        v.pos_z = rand_sgl();
        v.color = $urandom;
        v.tex_uv = {$urandom, $urandom};
        v.brightness = $urandom;
        v.mode = 2'($urandom_range(0, 3));
        v.tint = 24'($urandom);
        v.diffuse = rand_diffuse();
        v.off_x = rand_dbl();
        v.off_y = rand_dbl();
        v.off_z = rand_dbl();
        return v;
    endfunction

    function automatic vertex_t mk_vertex(logic [31:0] px, logic [31:0] color,
                                          logic [1:0] mode, logic [23:0] tint,
                                          logic [31:0] diffuse, logic [63:0] off);
        vertex_t v;
        v = '0;
        v.pos_x = px;
        v.pos_y = px ^ 32'h8000_0000;
        v.pos_z = px;
        v.color = color;
        v.tex_uv = 64'h0123_4567_89AB_CDEF;
        v.brightness = 32'h00F0_00F0;
        v.mode = mode;
        v.tint = tint;
        v.diffuse = diffuse;
        v.off_x = off;
        v.off_y = off ^ 64'h8000_0000_0000_0000;
        v.off_z = off;
        return v;
    endfunction

    task automatic add_row(vertex_t v, bit typed, logic [31:0] x, logic [31:0] color);
        vec_row_t r;
        r.v = v;
        r.typed = typed;
        r.want.x = x;
        r.want.y = x ^ 32'h8000_0000;
        r.want.z = x;
        r.want.color = color;
        r.want.tex_uv = v.tex_uv;
        r.want.light = v.brightness;
        vec_rows.push_back(r);
    endtask

    task automatic build_table();
        vertex_t v;
        // 1.0 + 1.0, color untouched
        add_row(mk_vertex(32'h3F80_0000, 32'hDEAD_BEEF, MODE_NONE, 24'h0, 32'h0,
                          64'h3FF0_0000_0000_0000), 1, 32'h4000_0000, 32'hDEAD_BEEF);
        // full tint is a factor of exactly one
        add_row(mk_vertex(32'h0, 32'h80FF_7F01, MODE_TINT, 24'hFFFFFF, 32'h0, 64'h0),
                1, 32'h0, 32'h80FF_7F01);
        add_row(mk_vertex(32'h0, 32'hAB12_3456, MODE_TINT, 24'h0, 32'h0, 64'h0),
                1, 32'h0, 32'hAB00_0000);
        // diffuse 2.0: 0x80 wraps to zero
        add_row(mk_vertex(32'h0, 32'h0080_1001, MODE_DIFF, 24'h0, 32'h4000_0000, 64'h0),
                1, 32'h0, 32'h0000_2002);
        // NaN and infinite diffuse zero every channel
        add_row(mk_vertex(32'h0, 32'h7F11_2233, MODE_DIFF, 24'h0, 32'h7FC0_0000, 64'h0),
                1, 32'h0, 32'h7F00_0000);
        add_row(mk_vertex(32'h0, 32'h7F11_2200, MODE_DIFF, 24'h0, 32'h7F80_0000, 64'h0),
                1, 32'h0, 32'h7F00_0000);
        add_row(mk_vertex(32'h0, 32'h00FF_8005, MODE_DIFF, 24'h0, 32'hBF80_0000, 64'h0), 0, 0, 0);
        add_row(mk_vertex(32'h0, 32'h12FF_FFFF, MODE_DIFF, 24'h0, 32'h7F00_0000, 64'h0), 0, 0, 0);
        add_row(mk_vertex(32'h4120_0000, 32'h55C3_7A19, MODE_BOTH, 24'h80FF40, 32'h3F00_0000,
                          64'hC000_0000_0000_0000), 0, 0, 0);
        add_row(mk_vertex(32'h0, 32'hFFFF_FFFF, MODE_BOTH, 24'hFFFFFF, 32'h3F7F_FFFF,
                          64'h0), 0, 0, 0);
        add_row(mk_vertex(32'h0, 32'h0102_0304, MODE_TINT, 24'h010203, 32'h0, 64'h0), 0, 0, 0);
        // offset extremes: NaN, infinity, overflow, underflow, rounding ties
        add_row(mk_vertex(32'h3F80_0000, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'h7FF8_0000_0000_0000), 0, 0, 0);
        add_row(mk_vertex(32'h3F80_0000, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'h7FF0_0000_0000_0000), 1, 32'h7F80_0000, 32'h0);
        add_row(mk_vertex(32'h3F80_0000, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'h47F0_0000_0000_0000), 1, 32'h7F80_0000, 32'h0);
        add_row(mk_vertex(32'h0, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'h36A0_0000_0000_0000), 1, 32'h0000_0001, 32'h0);
        add_row(mk_vertex(32'h0, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'h3FF0_0000_1000_0000), 1, 32'h3F80_0000, 32'h0);
        add_row(mk_vertex(32'h0, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'h3FF0_0000_3000_0000), 0, 0, 0);
        add_row(mk_vertex(32'h7F80_0000, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'hFFF0_0000_0000_0000), 0, 0, 0);
        add_row(mk_vertex(32'h7F7F_FFFF, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'h47EF_FFFF_F000_0000), 0, 0, 0);
        add_row(mk_vertex(32'h0000_0001, 32'h0, MODE_NONE, 24'h0, 32'h0,
                          64'hB6A0_0000_0000_0000), 0, 0, 0);
        v = '0;
        add_row(v, 0, 0, 0);
        v = '1;
        v.pad = '0;
        add_row(v, 0, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic push_vertex(vertex_t v, bit typed, shaded_t want);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = S_TDATA_W'(v);
        do @(posedge aclk); while (!s_axis_tready);
        pending_q.push_back(typed ? want : shade_vertex(v));
        n_sent++;
        @(negedge aclk);
    endtask

    initial begin
        build_table();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        foreach (vec_rows[i])
            push_vertex(vec_rows[i].v, vec_rows[i].typed, vec_rows[i].want);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) hold_req = 1'b1;
            if (i == 900) begin
                s_axis_tvalid = 1'b0;
                wait (pending_q.size() == 0);
                @(negedge aclk);
            end
            no_idle = (i >= 1200 && i < 1500);
            push_vertex(rand_vertex(), 0, '0);
        end
        s_axis_tvalid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (2 * PIPE_STAGES + 10) @(posedge aclk);
        $display("%0d vertices across all four color modes, %0d results checked,", n_sent, n_seen);
        $display("including NaN, infinite, overflowing and tie-rounded offsets and factors");
        if (n_bad == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // output side: random backpressure plus one long hold
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = no_idle || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge aclk) begin
        shaded_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = shaded_t'(m_axis_tdata);
            n_seen++;
            if (pending_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected beat %h", got);
            end else begin
                want = pending_q.pop_front();
                if (got != want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("beat %0d mismatch", n_seen);
                        $display("  x %h/%h y %h/%h z %h/%h", want.x, got.x,
                                 want.y, got.y, want.z, got.z);
                        $display("  color %h/%h uv %h/%h light %h/%h",
                                 want.color, got.color, want.tex_uv, got.tex_uv,
                                 want.light, got.light);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/vtlo_pkg.sv
sv/vtlo_pos_lane.sv
sv/vtlo_color_unit.sv
sv/vertex_tint_light_offset.sv
sv/vtlo_checker.sv
sim/tb.sv
